// File: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, constants and helpers of the scheduled servo duty unit
// ----------------------------------------------------------------------------
package ssd_pkg;

	// schedule table depth, one chain cell per entry
	localparam int ENTRIES = 8;

	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int IDX_W    = 3;
	localparam int PCT_W    = 7;
	localparam int DUTY_W   = 14;
	localparam int US_W     = 15;
	localparam int KEY_W    = 11;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_PERCENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN_US   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX_US   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY      = 3'd4;

	localparam logic [US_W-1:0]   PULSE_MIN_RST = 15'd500;
	localparam logic [US_W-1:0]   PULSE_MAX_RST = 15'd2500;
	localparam logic [DUTY_W-1:0] FULL_DUTY_RST = 14'd16383;

	// command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [PCT_W-1:0]  PCT_MAX      = 7'd100;
	localparam logic [DUTY_W-1:0] DUTY_MAX     = 14'd16383;
	localparam logic [KEY_W-1:0]  KEY_NONE     = 11'd2047;
	localparam logic [KEY_W-1:0]  MIN_PER_HOUR = 11'd60;

	// duty arithmetic: pulse*100 fits 22 bits, times full duty 36 bits,
	// the quotient by the period scale fits 15 bits
	localparam int PULSE_W = 22;
	localparam int PROD_W  = PULSE_W + DUTY_W;
	localparam int QUO_W   = 15;
	localparam int SCALE_W = 22;
	localparam logic [SCALE_W-1:0] PERIOD_SCALE = 22'd2000000;

	// period scale is 2^7 * 15625: drop seven bits, then multiply by
	// ceil(2^43 / 15625), exact for every dividend below 2^29
	localparam int SCALE_SHIFT = 7;
	localparam int SCALED_W    = PROD_W - SCALE_SHIFT;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 43;
	localparam int RPROD_W     = RECIP_SHIFT + QUO_W;
	localparam logic [RECIP_W-1:0] RECIP = 30'd562949954;

	typedef struct packed {
		logic                command;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [IDX_W-1:0]    entry_index;
		logic                entry_active;
		logic [PCT_W-1:0]    entry_percent;
	} ssd_in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [PCT_W-1:0]  position;
	} ssd_out_t;

	// search token walking the cell chain
	typedef struct packed {
		logic                valid;
		logic                hit;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [PCT_W-1:0]    pct;
	} ssd_srch_t;

	typedef struct packed {
		logic             start;
		logic [PCT_W-1:0] pct;
	} ssd_duty_req_t;

	typedef struct packed {
		logic              done;
		logic [DUTY_W-1:0] duty;
		logic [PCT_W-1:0]  pct;
	} ssd_duty_rsp_t;

	function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] p);
		return (p > PCT_MAX) ? PCT_MAX : p;
	endfunction

endpackage

// File: rtl/ssd_cell.sv
// ----------------------------------------------------------------------------
// ssd_cell
// one schedule entry plus one hop of the search chain
// ----------------------------------------------------------------------------
module ssd_cell import ssd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  ssd_in_t   wr_data,
	input  ssd_srch_t srch_in,
	output ssd_srch_t srch_out
);

	logic                enabled_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [PCT_W-1:0]    target_q;

	logic                vld_q;
	logic                hit_q;
	logic [HOUR_W-1:0]   s_hour_q;
	logic [MINUTE_W-1:0] s_minute_q;
	logic [PCT_W-1:0]    s_pct_q;

	logic match;

	// first enabled entry wins, later cells pass an earlier hit along
	assign match = !srch_in.hit && enabled_q &&
		(hour_q == srch_in.hour) && (minute_q == srch_in.minute);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				enabled_q <= wr_data.entry_active;
			end
			vld_q <= srch_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hour_q   <= wr_data.hour;
			minute_q <= wr_data.minute;
			target_q <= wr_data.entry_percent;
		end
		s_hour_q   <= srch_in.hour;
		s_minute_q <= srch_in.minute;
		hit_q      <= srch_in.hit | match;
		s_pct_q    <= match ? target_q : srch_in.pct;
	end

	assign srch_out = '{valid: vld_q, hit: hit_q, hour: s_hour_q,
		minute: s_minute_q, pct: s_pct_q};

endmodule

// File: rtl/ssd_duty.sv
// ----------------------------------------------------------------------------
// ssd_duty
// percent to duty count: two multiply steps and a reciprocal multiply
// ----------------------------------------------------------------------------
module ssd_duty import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [US_W-1:0]   pulse_min_us,
	input  logic [US_W-1:0]   pulse_max_us,
	input  logic [DUTY_W-1:0] full_duty,
	input  ssd_duty_req_t     req,
	output ssd_duty_rsp_t     rsp
);

	typedef enum logic [4:0] {
		D_IDLE  = 5'b00001,
		D_PULSE = 5'b00010,
		D_PROD  = 5'b00100,
		D_RECIP = 5'b01000,
		D_DONE  = 5'b10000
	} dstate_t;

	dstate_t state_q;
	logic [PCT_W-1:0]    pct_q;
	logic [PULSE_W-1:0]  pulse_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [QUO_W-1:0]    quo_q;

	logic [PROD_W-1:0]  prod;
	logic [RPROD_W-1:0] rprod;

	assign prod  = PROD_W'(pulse_q) * PROD_W'(full_duty);
	assign rprod = RPROD_W'(scaled_q) * RPROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_PULSE;
					end
				end
				D_PULSE: state_q <= D_PROD;
				D_PROD:  state_q <= D_RECIP;
				D_RECIP: state_q <= D_DONE;
				D_DONE:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			pct_q <= req.pct;
		end
		if (state_q == D_PULSE) begin
			// min*(100-pct) + max*pct, never negative
			pulse_q <= PULSE_W'(pulse_min_us) * PULSE_W'(PCT_MAX - pct_q)
				+ PULSE_W'(pulse_max_us) * PULSE_W'(pct_q);
		end
		if (state_q == D_PROD) begin
			scaled_q <= prod[PROD_W-1:SCALE_SHIFT];
		end
		if (state_q == D_RECIP) begin
			quo_q <= rprod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
		end
	end

	assign rsp.done = (state_q == D_DONE);
	assign rsp.duty = (quo_q > QUO_W'(DUTY_MAX)) ? DUTY_MAX : quo_q[DUTY_W-1:0];
	assign rsp.pct  = pct_q;

endmodule

// File: rtl/scheduled_servo_duty_unit.sv
// ----------------------------------------------------------------------------
// scheduled_servo_duty_unit
// servo position and duty from a time-of-day schedule or a manual percent
// ----------------------------------------------------------------------------
// Each input transfer is a table write or a time tick. A table write gives no
// result. In manual mode a tick gives the clamped manual percent and its duty;
// the result passes the duty unit and lands in the output register, and the
// input takes the next item once it is loaded. In schedule mode a tick whose
// hour*60+minute equals the last executed key gives no result and does not
// stall the input; otherwise a search token walks the row of ENTRIES table
// cells, one cell a cycle. A miss stalls the input until the token leaves the
// last cell; on a hit the clamped entry percent goes to the duty unit and the
// result then lands in the output register. The duty path steps through the
// pulse sum, the product with the full duty count, the reciprocal multiply for
// the constant period scale and done, before the output register is loaded.
// One tick is in flight at a time; the input stalls until the result sits in
// the output register, which then waits for the consumer while the next item
// may already be taken. Configuration is written through a plain write port
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
module scheduled_servo_duty_unit import ssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ssd_in_t               in_data,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output ssd_out_t              out_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_DUTY   = 4'b0100,
		ST_OUT    = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic              manual_mode_q;
	logic [PCT_W-1:0]  manual_level_q;
	logic [US_W-1:0]   pulse_min_q;
	logic [US_W-1:0]   pulse_max_q;
	logic [DUTY_W-1:0] full_duty_q;

	logic [KEY_W-1:0] last_key_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] key_new;

	logic     out_valid_q;
	ssd_out_t out_data_q;

	logic in_xfer;
	logic is_write;
	logic is_tick;
	logic out_free;

	ssd_srch_t     srch [ENTRIES+1];
	logic          wr_en [ENTRIES];
	ssd_duty_req_t duty_req;
	ssd_duty_rsp_t duty_rsp;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign is_write = in_xfer && (in_data.command == CMD_WRITE);
	assign is_tick  = in_xfer && (in_data.command == CMD_TICK);
	assign key_new  = KEY_W'(in_data.hour) * MIN_PER_HOUR + KEY_W'(in_data.minute);
	assign out_free = !out_valid_q || !out_stall;

	// ---- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_mode_q  <= 1'b0;
			manual_level_q <= '0;
			pulse_min_q    <= PULSE_MIN_RST;
			pulse_max_q    <= PULSE_MAX_RST;
			full_duty_q    <= FULL_DUTY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MANUAL_MODE:    manual_mode_q  <= cfg_data[0];
				CFG_MANUAL_PERCENT: manual_level_q <= cfg_data[PCT_W-1:0];
				CFG_PULSE_MIN_US:   pulse_min_q    <= cfg_data[US_W-1:0];
				CFG_PULSE_MAX_US:   pulse_max_q    <= cfg_data[US_W-1:0];
				CFG_FULL_DUTY:      full_duty_q    <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- schedule chain -----------------------------------------------------
	// token enters cell 0 only for a schedule tick with a fresh key
	assign srch[0] = '{
		valid:  is_tick && !manual_mode_q && (key_new != last_key_q),
		hit:    1'b0,
		hour:   in_data.hour,
		minute: in_data.minute,
		pct:    '0
	};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		// writes beyond the table decode to no cell
		assign wr_en[i] = is_write && (32'(in_data.entry_index) == i);

		ssd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[i]),
			.wr_data  (in_data),
			.srch_in  (srch[i]),
			.srch_out (srch[i+1])
		);
	end

	// ---- duty unit ----------------------------------------------------------
	always_comb begin
		duty_req = '{start: 1'b0, pct: '0};
		if (state_q == ST_IDLE && is_tick && manual_mode_q) begin
			duty_req = '{start: 1'b1, pct: clamp_pct(manual_level_q)};
		end else if (state_q == ST_SEARCH && srch[ENTRIES].valid && srch[ENTRIES].hit) begin
			duty_req = '{start: 1'b1, pct: clamp_pct(srch[ENTRIES].pct)};
		end
	end

	ssd_duty u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.pulse_min_us (pulse_min_q),
		.pulse_max_us (pulse_max_q),
		.full_duty    (full_duty_q),
		.req          (duty_req),
		.rsp          (duty_rsp)
	);

	// ---- sequencer ----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_key_q <= KEY_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (duty_req.start) begin
						state_q <= ST_DUTY;
					end else if (srch[0].valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// wait until the token leaves the last cell
					if (srch[ENTRIES].valid) begin
						if (srch[ENTRIES].hit) begin
							last_key_q <= key_q;
							state_q    <= ST_DUTY;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DUTY: begin
					if (duty_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (srch[0].valid) begin
			key_q <= key_new;
		end
	end

	// ---- output register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= '{duty: duty_rsp.duty, position: duty_rsp.pct};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// port-level checks of the scheduled servo duty unit
// ----------------------------------------------------------------------------
module ssd_checker import ssd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input ssd_in_t  in_data,
	input logic     out_valid,
	input logic     out_stall,
	input ssd_out_t out_data
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// position is always clamped
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.position <= PCT_MAX)
		else $error("position above 100");

	// a new result only appears while an item is being worked on
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a busy item");

	// a table write transfer never makes a result on its own
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.command == CMD_WRITE && !out_valid
		|=> !out_valid)
		else $error("result after table write");

endmodule

bind scheduled_servo_duty_unit ssd_checker u_ssd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
